>>> rtl/core/bmpdec_pkg.sv
// Shared types and constants for the BMP stream to RGBA decoder.
package bmpdec_pkg;

  // Image limits and palette size
  localparam int MAX_WIDTH       = 4096;
  localparam int MAX_HEIGHT      = 4096;
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_ADDR_W      = $clog2(PALETTE_ENTRIES);
  localparam int PAL_DATA_W      = 24;

  // Stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_USED_W  = 35;

  // File layout
  localparam logic [31:0] HDR_END    = 32'd54;
  localparam logic [31:0] PAL_END    = HDR_END + 32'(4 * PALETTE_ENTRIES);
  localparam logic [31:0] INFO_SIZE  = 32'd40;
  localparam logic [31:0] POS_SIG_B  = 32'd0;
  localparam logic [31:0] POS_SIG_M  = 32'd1;
  localparam logic [31:0] POS_OFFSET = 32'd13;
  localparam logic [31:0] POS_INFO   = 32'd17;
  localparam logic [31:0] POS_WIDTH  = 32'd21;
  localparam logic [31:0] POS_HEIGHT = 32'd25;
  localparam logic [31:0] POS_BPP    = 32'd29;
  localparam logic [31:0] POS_COMPR  = 32'd33;

  localparam logic [7:0] ASCII_B      = 8'h42;
  localparam logic [7:0] ASCII_M      = 8'h4D;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic [5:0] BPP_8  = 6'd8;
  localparam logic [5:0] BPP_24 = 6'd24;
  localparam logic [5:0] BPP_32 = 6'd32;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_GAP,
    PH_PIXEL,
    PH_PAD,
    PH_DONE,
    PH_IDLE
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_SIGNATURE,
    ERR_HEADER,
    ERR_BPP,
    ERR_GEOMETRY
  } err_code_t;

  typedef enum logic {
    KIND_PIXEL,
    KIND_ERROR
  } kind_t;

  // One result beat as it leaves the parser
  typedef struct packed {
    kind_t       kind;
    logic        use_pal;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    err_code_t   error_code;
    logic        last;
  } result_t;

  // Palette RAM access from the parser
  typedef struct packed {
    logic                  wr_en;
    logic [PAL_ADDR_W-1:0] wr_addr;
    logic [PAL_DATA_W-1:0] wr_data;
    logic                  rd_en;
    logic [PAL_ADDR_W-1:0] rd_addr;
  } pal_port_t;

endpackage

>>> rtl/core/bmp_stream_to_rgba_decoder.sv
// Top level of the BMP stream to RGBA decoder.
// Takes one file byte per beat and accepts a byte in every cycle while the
// output side keeps up; a stalled output still leaves room for one more
// result. A pixel or error beat reaches the master side through one result
// register (aligned with the registered read of the 256-entry palette RAM)
// and then one output register. The palette RAM has no reset and no
// clearing pass; an 8 bpp file always loads all 256 entries before its
// first pixel. Bytes that complete no pixel and raise no error, and every
// byte after an error report until the next start of file, give no output beat.
module bmp_stream_to_rgba_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] start_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                 // [31:24] alpha, [34:32] error_code, rest zero
  output logic        m_tuser,   // [0] kind
  output logic        m_tlast    // last_pixel
);

  logic                  accept;
  logic                  ready;
  logic                  res_valid;
  bmpdec_pkg::result_t   res;
  bmpdec_pkg::pal_port_t pal;
  logic [bmpdec_pkg::PAL_DATA_W-1:0] pal_data;

  assign s_tready = ready;
  assign accept   = s_tvalid && ready;

  bmpdec_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (s_tdata),
    .start_of_file (s_tuser),
    .res_valid     (res_valid),
    .res           (res),
    .pal           (pal)
  );

  bmpdec_ram #(
    .WIDTH (bmpdec_pkg::PAL_DATA_W),
    .DEPTH (bmpdec_pkg::PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (pal.wr_en),
    .wr_addr (pal.wr_addr),
    .wr_data (pal.wr_data),
    .rd_en   (pal.rd_en),
    .rd_addr (pal.rd_addr),
    .rd_data (pal_data)
  );

  bmpdec_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res_valid (res_valid),
    .res       (res),
    .pal_data  (pal_data),
    .ready     (ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

>>> rtl/core/bmpdec_ram.sv
// Generic single-port-write, registered-read RAM.
module bmpdec_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/bmpdec_parser.sv
// Byte parser: header checks, palette load, pixel assembly and row padding.
module bmpdec_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 start_of_file,
  output logic                 res_valid,
  output bmpdec_pkg::result_t  res,
  output bmpdec_pkg::pal_port_t pal
);

  // state registers
  logic [31:0]         byte_position, byte_position_next;
  logic [31:0]         data_offset, data_offset_next;
  logic [12:0]         image_width, image_width_next;
  logic [12:0]         image_height, image_height_next;
  logic [5:0]          bits_per_pixel, bits_per_pixel_next;
  logic [31:0]         header_word, header_word_next;
  bmpdec_pkg::phase_t  phase, phase_next;
  logic [12:0]         row_count, row_count_next;
  logic [12:0]         column_count, column_count_next;
  logic [1:0]          byte_in_pixel, byte_in_pixel_next;
  logic [1:0]          padding_left, padding_left_next;
  logic [23:0]         partial_pixel, partial_pixel_next;

  // state as seen by this beat (start of file restarts everything)
  logic [31:0]         pos;
  bmpdec_pkg::phase_t  phase_e;
  logic [31:0]         offset_e;
  logic [12:0]         width_e, height_e;
  logic [5:0]          bpp_e;
  logic [31:0]         hdr_e;
  logic [12:0]         row_e, col_e;
  logic [1:0]          bip_e, pad_e;
  logic [23:0]         part_e;

  // row padding in bytes for the current width and bit count
  logic [1:0]          row_pad;

  always_comb begin
    pos      = start_of_file ? '0 : byte_position;
    phase_e  = start_of_file ? bmpdec_pkg::PH_HEADER : phase;
    offset_e = start_of_file ? '0 : data_offset;
    width_e  = start_of_file ? '0 : image_width;
    height_e = start_of_file ? '0 : image_height;
    bpp_e    = start_of_file ? '0 : bits_per_pixel;
    hdr_e    = start_of_file ? '0 : header_word;
    row_e    = start_of_file ? '0 : row_count;
    col_e    = start_of_file ? '0 : column_count;
    bip_e    = start_of_file ? '0 : byte_in_pixel;
    pad_e    = start_of_file ? '0 : padding_left;
    part_e   = start_of_file ? '0 : partial_pixel;
  end

  // 8 bpp: rows of w bytes; 24 bpp: 3w bytes, pad is w mod 4; 32 bpp never pads
  always_comb begin
    case (bpp_e)
      bmpdec_pkg::BPP_8:  row_pad = 2'(2'd0 - width_e[1:0]);
      bmpdec_pkg::BPP_24: row_pad = width_e[1:0];
      default:            row_pad = 2'd0;
    endcase
  end

  // next state and result
  always_comb begin
    logic [31:0] hw;
    logic [31:0] rel;
    logic [15:0] bc;
    logic [31:0] min_off;
    logic        do_pixel;
    logic        emit;
    logic [12:0] row_i, col_i, col_inc, row_inc;
    logic [1:0]  bip_i;
    logic [23:0] part_i;

    hw      = {data_byte, hdr_e[31:8]};
    rel     = pos - bmpdec_pkg::HDR_END;
    bc      = hw[31:16];
    min_off = (bpp_e == bmpdec_pkg::BPP_8) ? bmpdec_pkg::PAL_END : bmpdec_pkg::HDR_END;
    do_pixel = 1'b0;
    emit     = 1'b0;
    row_i   = row_e;
    col_i   = col_e;
    bip_i   = bip_e;
    part_i  = part_e;
    col_inc = '0;
    row_inc = '0;

    byte_position_next  = pos + 32'd1;
    data_offset_next    = offset_e;
    image_width_next    = width_e;
    image_height_next   = height_e;
    bits_per_pixel_next = bpp_e;
    header_word_next    = hdr_e;
    phase_next          = phase_e;
    row_count_next      = row_e;
    column_count_next   = col_e;
    byte_in_pixel_next  = bip_e;
    padding_left_next   = pad_e;
    partial_pixel_next  = part_e;

    res_valid      = 1'b0;
    res            = '0;
    res.kind       = bmpdec_pkg::KIND_PIXEL;
    res.error_code = bmpdec_pkg::ERR_NONE;
    pal            = '0;

    case (phase_e)
      bmpdec_pkg::PH_HEADER: begin
        header_word_next = hw;
        case (pos)
          bmpdec_pkg::POS_SIG_B: begin
            if (data_byte != bmpdec_pkg::ASCII_B) begin
              res.error_code = bmpdec_pkg::ERR_SIGNATURE;
            end
          end
          bmpdec_pkg::POS_SIG_M: begin
            if (data_byte != bmpdec_pkg::ASCII_M) begin
              res.error_code = bmpdec_pkg::ERR_SIGNATURE;
            end
          end
          bmpdec_pkg::POS_OFFSET: data_offset_next = hw;
          bmpdec_pkg::POS_INFO: begin
            if (hw != bmpdec_pkg::INFO_SIZE) begin
              res.error_code = bmpdec_pkg::ERR_HEADER;
            end
          end
          bmpdec_pkg::POS_WIDTH: begin
            image_width_next = (hw != 32'd0 && hw <= 32'(bmpdec_pkg::MAX_WIDTH)) ?
                               hw[12:0] : 13'd0;
          end
          bmpdec_pkg::POS_HEIGHT: begin
            image_height_next = (hw != 32'd0 && hw <= 32'(bmpdec_pkg::MAX_HEIGHT)) ?
                                hw[12:0] : 13'd0;
          end
          bmpdec_pkg::POS_BPP: begin
            bits_per_pixel_next = (bc inside {16'd8, 16'd24, 16'd32}) ? bc[5:0] : 6'd0;
          end
          bmpdec_pkg::POS_COMPR: begin
            if (hw != 32'd0) begin
              res.error_code = bmpdec_pkg::ERR_HEADER;
            end else if (bpp_e == 6'd0) begin
              res.error_code = bmpdec_pkg::ERR_BPP;
            end else if (width_e == 13'd0 || height_e == 13'd0) begin
              res.error_code = bmpdec_pkg::ERR_GEOMETRY;
            end else if (offset_e < min_off) begin
              res.error_code = bmpdec_pkg::ERR_GEOMETRY;
            end else begin
              phase_next = bmpdec_pkg::PH_GAP;
            end
          end
          default: ;
        endcase
        if (res.error_code != bmpdec_pkg::ERR_NONE) begin
          res_valid  = 1'b1;
          res.kind   = bmpdec_pkg::KIND_ERROR;
          phase_next = bmpdec_pkg::PH_IDLE;
        end
      end

      bmpdec_pkg::PH_GAP: begin
        if (pos == offset_e) begin
          // first pixel byte: start the pixel counters fresh
          phase_next = bmpdec_pkg::PH_PIXEL;
          row_i    = '0;
          col_i    = '0;
          bip_i    = '0;
          part_i   = '0;
          do_pixel = 1'b1;
        end else if (bpp_e == bmpdec_pkg::BPP_8 && pos >= bmpdec_pkg::HDR_END &&
                     pos < bmpdec_pkg::PAL_END) begin
          // palette entries are B,G,R,x; collect B and G, write on R
          case (rel[1:0])
            2'd0: partial_pixel_next[7:0]  = data_byte;
            2'd1: partial_pixel_next[15:8] = data_byte;
            2'd2: begin
              pal.wr_en   = accept;
              pal.wr_addr = rel[bmpdec_pkg::PAL_ADDR_W+1:2];
              pal.wr_data = {data_byte, part_e[15:0]};
            end
            default: ;
          endcase
        end
      end

      bmpdec_pkg::PH_PIXEL: do_pixel = 1'b1;

      bmpdec_pkg::PH_PAD: begin
        padding_left_next = pad_e - 2'd1;
        if (pad_e == 2'd1) begin
          phase_next = bmpdec_pkg::PH_PIXEL;
        end
      end

      default: ;
    endcase

    // pixel assembly
    if (do_pixel) begin
      row_count_next     = row_i;
      column_count_next  = col_i;
      byte_in_pixel_next = bip_i;
      partial_pixel_next = part_i;
      if (bpp_e == bmpdec_pkg::BPP_8) begin
        pal.rd_en   = accept;
        pal.rd_addr = data_byte;
        res.use_pal = 1'b1;
        res.alpha   = bmpdec_pkg::ALPHA_OPAQUE;
        emit        = 1'b1;
      end else begin
        case (bip_i)
          2'd0: begin
            partial_pixel_next = {16'd0, data_byte};
            byte_in_pixel_next = 2'd1;
          end
          2'd1: begin
            partial_pixel_next = {part_i[23:16], data_byte, part_i[7:0]};
            byte_in_pixel_next = 2'd2;
          end
          2'd2: begin
            if (bpp_e == bmpdec_pkg::BPP_24) begin
              byte_in_pixel_next = 2'd0;
              res.red   = data_byte;
              res.green = part_i[15:8];
              res.blue  = part_i[7:0];
              res.alpha = bmpdec_pkg::ALPHA_OPAQUE;
              emit      = 1'b1;
            end else begin
              partial_pixel_next = {data_byte, part_i[15:0]};
              byte_in_pixel_next = 2'd3;
            end
          end
          default: begin
            byte_in_pixel_next = 2'd0;
            res.red   = part_i[23:16];
            res.green = part_i[15:8];
            res.blue  = part_i[7:0];
            res.alpha = data_byte;
            emit      = 1'b1;
          end
        endcase
      end

      // column and row bookkeeping on each pixel
      if (emit) begin
        res_valid = 1'b1;
        col_inc   = col_i + 13'd1;
        row_inc   = row_i + 13'd1;
        if (col_inc == width_e) begin
          column_count_next = '0;
          row_count_next    = row_inc;
          if (row_inc == height_e) begin
            res.last   = 1'b1;
            phase_next = bmpdec_pkg::PH_DONE;
          end else if (row_pad != 2'd0) begin
            padding_left_next = row_pad;
            phase_next        = bmpdec_pkg::PH_PAD;
          end
        end else begin
          column_count_next = col_inc;
        end
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      data_offset    <= '0;
      image_width    <= '0;
      image_height   <= '0;
      bits_per_pixel <= '0;
      header_word    <= '0;
      phase          <= bmpdec_pkg::PH_HEADER;
      row_count      <= '0;
      column_count   <= '0;
      byte_in_pixel  <= '0;
      padding_left   <= '0;
      partial_pixel  <= '0;
    end else if (accept) begin
      byte_position  <= byte_position_next;
      data_offset    <= data_offset_next;
      image_width    <= image_width_next;
      image_height   <= image_height_next;
      bits_per_pixel <= bits_per_pixel_next;
      header_word    <= header_word_next;
      phase          <= phase_next;
      row_count      <= row_count_next;
      column_count   <= column_count_next;
      byte_in_pixel  <= byte_in_pixel_next;
      padding_left   <= padding_left_next;
      partial_pixel  <= partial_pixel_next;
    end
  end

endmodule

>>> rtl/core/bmpdec_out.sv
// Result stage and output register; merges palette read data into 8 bpp pixels.
module bmpdec_out (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  logic                              res_valid,
  input  bmpdec_pkg::result_t               res,
  input  logic [bmpdec_pkg::PAL_DATA_W-1:0] pal_data,
  output logic                              ready,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bmpdec_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                              m_tuser,
  output logic                              m_tlast
);

  // stage one: result aligned with the palette read
  logic                r1_valid;
  bmpdec_pkg::result_t r1;

  // stage two: output register
  logic                r2_valid;
  logic                out_kind;
  logic [31:0]         out_rgba;
  logic [2:0]          out_code;
  logic                out_last;

  logic                r2_free;
  logic [23:0]         rgb;

  assign r2_free = !r2_valid || m_tready;
  assign ready   = !r1_valid || r2_free;
  assign rgb     = r1.use_pal ? pal_data : {r1.red, r1.green, r1.blue};

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
      r2_valid <= 1'b0;
    end else begin
      if (load) begin
        r1_valid <= res_valid;
      end else if (r2_free) begin
        r1_valid <= 1'b0;
      end
      if (r2_free) begin
        r2_valid <= r1_valid;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      r1 <= res;
    end
    if (r2_free && r1_valid) begin
      out_kind <= r1.kind;
      out_rgba <= {r1.alpha, rgb[7:0], rgb[15:8], rgb[23:16]};
      out_code <= r1.error_code;
      out_last <= r1.last;
    end
  end

  assign m_tvalid = r2_valid;
  assign m_tdata  = {5'd0, out_code, out_rgba};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

endmodule

>>> rtl/core/bmpdec_checker.sv
// Port-level checks for the BMP decoder, bound to the top level.
module bmpdec_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("output beat changed while stalled");

  // error reports carry a code, no color and no last flag
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[31:0] == 32'd0 && !m_tlast &&
                            m_tdata[34:32] != 3'(bmpdec_pkg::ERR_NONE))
    else $error("malformed error report");

  // pixel beats carry no error code
  a_pix_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[34:32] == 3'(bmpdec_pkg::ERR_NONE))
    else $error("pixel beat with error code");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind bmp_stream_to_rgba_decoder bmpdec_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
